@@ src/hte_pkg.sv @@
// Shared types and constants for the HTML text extractor.
// Holds the controller/datapath command and status structs and the match tables.
// No dependencies.
package hte_pkg;

    // Only the first seven tag characters can change the outcome of a match.
    localparam int NAME_KEEP  = 7;
    localparam int TAG_LEN_W  = $clog2(NAME_KEEP + 1);

    // Entity look-ahead buffer.
    localparam int ENT_DEPTH  = 5;
    localparam int ENT_SPAN   = 6;
    localparam int ENT_COUNT  = 4;
    localparam int ELEN_W     = $clog2(ENT_SPAN + 1);
    localparam int EIDX_W     = $clog2(ENT_DEPTH);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Tag name patterns, first character in the top byte.
    localparam logic [8*NAME_KEEP-1:0] TAG_SCRIPT     = {"script", 8'h00};
    localparam logic [8*NAME_KEEP-1:0] TAG_STYLE      = {"style", 16'h0000};
    localparam logic [8*NAME_KEEP-1:0] TAG_END_SCRIPT = "/script";
    localparam logic [8*NAME_KEEP-1:0] TAG_END_STYLE  = {"/style", 8'h00};
    localparam logic [8*NAME_KEEP-1:0] TAG_BR         = {"br", 40'h0};
    localparam logic [8*NAME_KEEP-1:0] TAG_END_P      = {"/p", 40'h0};
    localparam logic [8*NAME_KEEP-1:0] TAG_END_DIV    = {"/div", 24'h0};
    localparam logic [8*NAME_KEEP-1:0] TAG_END_H      = {"/h", 40'h0};
    localparam logic [8*NAME_KEEP-1:0] TAG_P          = {"p", 48'h0};
    localparam logic [8*NAME_KEEP-1:0] TAG_LI         = {"li", 40'h0};

    // Entity table: text, length and decoded character.
    localparam logic [7:0] ENT_TEXT [ENT_COUNT][ENT_SPAN] = '{
        '{"&", "a", "m", "p", ";", 8'h00},
        '{"&", "l", "t", ";", 8'h00, 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00},
        '{"&", "n", "b", "s", "p", ";"}
    };
    localparam logic [ELEN_W-1:0] ENT_LEN [ENT_COUNT] = '{
        ELEN_W'(5), ELEN_W'(4), ELEN_W'(4), ELEN_W'(6)
    };
    localparam logic [7:0] ENT_VAL [ENT_COUNT] = '{CH_AMP, CH_LT, CH_GT, CH_SPACE};

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FEED,
        OP_FLUSH,
        OP_REPLAY,
        OP_PLAIN,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              to_hold;
        logic              load_byte;
        logic [EIDX_W-1:0] rep_idx;
    } t_cmd;

    typedef struct packed {
        logic              out_free;
        logic              broken;
        logic              pending;
        logic [ELEN_W-1:0] ent_len;
    } t_stat;

endpackage

@@ src/hte_datapath.sv @@
// Datapath of the HTML text extractor: tag and entity state, space collapsing,
// end-of-document hold register and the output register.
// Depends on hte_pkg.
module hte_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_byte,
    input  hte_pkg::t_cmd  i_cmd,
    output hte_pkg::t_stat o_stat,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    output logic [7:0]     o_m_tdata,
    output logic           o_m_tuser,
    output logic           o_m_tlast
);
    import hte_pkg::*;

    logic                 r_in_tag, n_in_tag;
    logic                 r_in_script, n_in_script;
    logic [7:0]           r_name [NAME_KEEP];
    logic [7:0]           n_name [NAME_KEEP];
    logic [TAG_LEN_W-1:0] r_tag_len, n_tag_len;
    logic [7:0]           r_ebuf [ENT_DEPTH];
    logic [7:0]           n_ebuf [ENT_DEPTH];
    logic [ELEN_W-1:0]    r_elen, n_elen;
    logic                 r_pend, n_pend;
    logic                 r_aspace, n_aspace;
    logic [7:0]           r_byte, n_byte;
    logic                 r_o_valid, n_o_valid;
    logic [7:0]           r_o_char, n_o_char;
    logic                 r_o_cv, n_o_cv;
    logic                 r_o_last, n_o_last;
    logic                 r_h_valid, n_h_valid;
    logic [7:0]           r_h_char, n_h_char;

    logic [8*NAME_KEEP-1:0] w_name;
    logic [7:0]             w_ebuf6 [ENT_SPAN];
    logic                   w_full, w_prefix, w_broken;
    logic [7:0]             w_full_val;
    logic [7:0]             w_rep_byte, w_src;
    logic                   w_open, w_close, w_nl;
    logic                   w_em;
    logic                   em_req;
    logic [7:0]             em_char;

    function automatic logic name_starts(input logic [8*NAME_KEEP-1:0] nm,
                                         input logic [TAG_LEN_W-1:0]   len,
                                         input logic [8*NAME_KEEP-1:0] pat,
                                         input int                     plen);
        logic hit;
        hit = (len >= TAG_LEN_W'(plen));
        for (int i = 0; i < NAME_KEEP; i++) begin
            if (i < plen && nm[8*(NAME_KEEP-1-i) +: 8] != pat[8*(NAME_KEEP-1-i) +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    always_comb begin
        for (int i = 0; i < NAME_KEEP; i++) begin
            w_name[8*(NAME_KEEP-1-i) +: 8] = r_name[i];
        end
    end

    assign w_open  = name_starts(w_name, r_tag_len, TAG_SCRIPT, 6) ||
                     name_starts(w_name, r_tag_len, TAG_STYLE, 5);
    assign w_close = name_starts(w_name, r_tag_len, TAG_END_SCRIPT, 7) ||
                     name_starts(w_name, r_tag_len, TAG_END_STYLE, 6);
    assign w_nl    = name_starts(w_name, r_tag_len, TAG_BR, 2) ||
                     name_starts(w_name, r_tag_len, TAG_END_P, 2) ||
                     name_starts(w_name, r_tag_len, TAG_END_DIV, 4) ||
                     name_starts(w_name, r_tag_len, TAG_END_H, 2) ||
                     name_starts(w_name, r_tag_len, TAG_P, 1) ||
                     name_starts(w_name, r_tag_len, TAG_LI, 2);

    // Entity match of the incoming byte against the buffered prefix.
    always_comb begin
        logic ok;
        for (int i = 0; i < ENT_DEPTH; i++) begin
            w_ebuf6[i] = r_ebuf[i];
        end
        w_ebuf6[ENT_SPAN-1] = '0;
        w_full     = 1'b0;
        w_prefix   = 1'b0;
        w_full_val = '0;
        for (int k = 0; k < ENT_COUNT; k++) begin
            ok = (ENT_LEN[k] > r_elen);
            for (int i = 0; i < ENT_SPAN; i++) begin
                if (ELEN_W'(i) < r_elen) begin
                    ok = ok && (w_ebuf6[i] == ENT_TEXT[k][i]);
                end else if (ELEN_W'(i) == r_elen) begin
                    ok = ok && (i_byte == ENT_TEXT[k][i]);
                end
            end
            if (ok) begin
                if (ENT_LEN[k] == r_elen + ELEN_W'(1)) begin
                    w_full     = 1'b1;
                    w_full_val = ENT_VAL[k];
                end else begin
                    w_prefix = 1'b1;
                end
            end
        end
    end

    assign w_broken = r_pend && !w_full && !(w_prefix && r_elen < ELEN_W'(ENT_DEPTH));

    always_comb begin
        w_rep_byte = '0;
        for (int j = 0; j < ENT_DEPTH; j++) begin
            if (i_cmd.rep_idx == EIDX_W'(j)) begin
                w_rep_byte = r_ebuf[j];
            end
        end
    end

    always_comb begin
        unique case (i_cmd.op)
            OP_FEED:  w_src = i_byte;
            OP_PLAIN: w_src = r_byte;
            default:  w_src = w_rep_byte;
        endcase
    end

    assign o_stat.out_free = !r_o_valid || i_m_tready;
    assign o_stat.broken   = w_broken;
    assign o_stat.pending  = r_pend;
    assign o_stat.ent_len  = r_elen;

    always_comb begin
        logic do_plain;
        logic is_alnum;
        logic is_upper;
        n_in_tag    = r_in_tag;
        n_in_script = r_in_script;
        n_name      = r_name;
        n_tag_len   = r_tag_len;
        n_ebuf      = r_ebuf;
        n_elen      = r_elen;
        n_pend      = r_pend;
        n_aspace    = r_aspace;
        n_byte      = i_cmd.load_byte ? i_byte : r_byte;
        em_req      = 1'b0;
        em_char     = '0;
        do_plain    = 1'b0;
        w_em        = 1'b0;

        unique case (i_cmd.op)
            OP_FEED: begin
                if (!r_pend) begin
                    do_plain = 1'b1;
                end else if (w_full) begin
                    n_pend  = 1'b0;
                    n_elen  = '0;
                    em_req  = 1'b1;
                    em_char = w_full_val;
                end else begin
                    for (int j = 0; j < ENT_DEPTH; j++) begin
                        if (r_elen == ELEN_W'(j)) begin
                            n_ebuf[j] = i_byte;
                        end
                    end
                    n_elen = r_elen + ELEN_W'(1);
                end
            end
            OP_FLUSH: begin
                // Broken entity: one space, the look-ahead after the '&' is then replayed as text.
                n_pend  = 1'b0;
                n_elen  = '0;
                em_req  = 1'b1;
                em_char = CH_SPACE;
            end
            OP_REPLAY, OP_PLAIN: do_plain = 1'b1;
            OP_FIN: begin
                n_in_tag    = 1'b0;
                n_in_script = 1'b0;
                n_tag_len   = '0;
                n_elen      = '0;
                n_pend      = 1'b0;
                n_aspace    = 1'b0;
            end
            OP_NONE: ;
        endcase

        is_upper = (w_src >= "A") && (w_src <= "Z");
        is_alnum = is_upper || ((w_src >= "a") && (w_src <= "z")) ||
                   ((w_src >= "0") && (w_src <= "9"));

        if (do_plain) begin
            priority if (w_src == CH_LT) begin
                n_in_tag  = 1'b1;
                n_tag_len = '0;
            end else if (r_in_tag) begin
                if (w_src == CH_GT) begin
                    n_in_tag = 1'b0;
                    if (w_open) begin
                        n_in_script = 1'b1;
                    end
                    if (w_close) begin
                        n_in_script = 1'b0;
                    end
                    if (w_nl) begin
                        em_req  = 1'b1;
                        em_char = CH_LF;
                    end
                end else if (r_tag_len < TAG_LEN_W'(NAME_KEEP) &&
                             (is_alnum || w_src == CH_SLASH)) begin
                    for (int j = 0; j < NAME_KEEP; j++) begin
                        if (r_tag_len == TAG_LEN_W'(j)) begin
                            n_name[j] = is_upper ? w_src + 8'd32 : w_src;
                        end
                    end
                    n_tag_len = r_tag_len + TAG_LEN_W'(1);
                end
            end else if (r_in_script) begin
                // Script and style bodies are dropped.
            end else if (w_src == CH_AMP) begin
                n_pend    = 1'b1;
                n_ebuf[0] = CH_AMP;
                n_elen    = ELEN_W'(1);
            end else if (w_src == CH_CR) begin
                // Carriage returns are dropped.
            end else if (w_src == CH_LF || w_src == CH_TAB) begin
                em_req  = 1'b1;
                em_char = CH_SPACE;
            end else begin
                em_req  = 1'b1;
                em_char = w_src;
            end
        end

        // Space collapsing: a newline also swallows the spaces after it.
        if (em_req) begin
            if (em_char == CH_SPACE) begin
                w_em     = !r_aspace;
                n_aspace = 1'b1;
            end else begin
                w_em     = 1'b1;
                n_aspace = (em_char == CH_LF);
            end
        end
    end

    // Output register and the one-deep hold used while the end of a document is found.
    always_comb begin
        n_o_valid = r_o_valid && !i_m_tready;
        n_o_char  = r_o_char;
        n_o_cv    = r_o_cv;
        n_o_last  = r_o_last;
        n_h_valid = r_h_valid;
        n_h_char  = r_h_char;
        if (i_cmd.op == OP_FIN) begin
            n_o_valid = 1'b1;
            n_o_char  = r_h_valid ? r_h_char : '0;
            n_o_cv    = r_h_valid;
            n_o_last  = 1'b1;
            n_h_valid = 1'b0;
        end else if (w_em) begin
            if (i_cmd.to_hold) begin
                n_h_valid = 1'b1;
                n_h_char  = em_char;
                if (r_h_valid) begin
                    n_o_valid = 1'b1;
                    n_o_char  = r_h_char;
                    n_o_cv    = 1'b1;
                    n_o_last  = 1'b0;
                end
            end else begin
                n_o_valid = 1'b1;
                n_o_char  = em_char;
                n_o_cv    = 1'b1;
                n_o_last  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag    <= 1'b0;
            r_in_script <= 1'b0;
            r_tag_len   <= '0;
            r_elen      <= '0;
            r_pend      <= 1'b0;
            r_aspace    <= 1'b0;
            r_o_valid   <= 1'b0;
            r_h_valid   <= 1'b0;
        end else begin
            r_in_tag    <= n_in_tag;
            r_in_script <= n_in_script;
            r_tag_len   <= n_tag_len;
            r_elen      <= n_elen;
            r_pend      <= n_pend;
            r_aspace    <= n_aspace;
            r_o_valid   <= n_o_valid;
            r_h_valid   <= n_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_name   <= n_name;
        r_ebuf   <= n_ebuf;
        r_byte   <= n_byte;
        r_o_char <= n_o_char;
        r_o_cv   <= n_o_cv;
        r_o_last <= n_o_last;
        r_h_char <= n_h_char;
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_char;
    assign o_m_tuser  = r_o_cv;
    assign o_m_tlast  = r_o_last;

endmodule

@@ src/hte_ctrl.sv @@
// Controller of the HTML text extractor: sequences broken-entity replay and
// the end-of-document flush. Depends on hte_pkg.
module hte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tlast,
    output logic           o_s_tready,
    input  hte_pkg::t_stat i_stat,
    output hte_pkg::t_cmd  o_cmd
);
    import hte_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPLAY,
        ST_BYTE,
        ST_END
    } t_state;

    t_state            r_state, n_state;
    logic              r_end, n_end;
    logic [EIDX_W-1:0] r_rep_idx, n_rep_idx;
    logic [ELEN_W-1:0] r_rep_n, n_rep_n;
    logic              r_then_byte, n_then_byte;
    logic              w_ready;

    always_comb begin
        n_state       = r_state;
        n_end         = r_end;
        n_rep_idx     = r_rep_idx;
        n_rep_n       = r_rep_n;
        n_then_byte   = r_then_byte;
        w_ready       = 1'b0;
        o_cmd.op        = OP_NONE;
        o_cmd.to_hold   = r_end;
        o_cmd.load_byte = 1'b0;
        o_cmd.rep_idx   = r_rep_idx;

        unique case (r_state)
            ST_IDLE: begin
                w_ready = i_stat.out_free;
                if (i_s_tvalid && w_ready) begin
                    o_cmd.to_hold = i_s_tlast;
                    n_end         = i_s_tlast;
                    if (i_stat.broken) begin
                        o_cmd.op        = OP_FLUSH;
                        o_cmd.load_byte = 1'b1;
                        n_rep_n         = i_stat.ent_len;
                        n_rep_idx       = EIDX_W'(1);
                        n_then_byte     = 1'b1;
                        n_state = (i_stat.ent_len > ELEN_W'(1)) ? ST_REPLAY : ST_BYTE;
                    end else begin
                        o_cmd.op = OP_FEED;
                        n_state  = i_s_tlast ? ST_END : ST_IDLE;
                    end
                end
            end
            ST_REPLAY: begin
                if (i_stat.out_free) begin
                    o_cmd.op  = OP_REPLAY;
                    n_rep_idx = r_rep_idx + EIDX_W'(1);
                    if (r_rep_idx == EIDX_W'(r_rep_n - ELEN_W'(1))) begin
                        n_state = r_then_byte ? ST_BYTE : ST_END;
                    end
                end
            end
            ST_BYTE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_PLAIN;
                    n_state  = r_end ? ST_END : ST_IDLE;
                end
            end
            ST_END: begin
                if (i_stat.out_free) begin
                    if (i_stat.pending) begin
                        o_cmd.op    = OP_FLUSH;
                        n_rep_n     = i_stat.ent_len;
                        n_rep_idx   = EIDX_W'(1);
                        n_then_byte = 1'b0;
                        n_state = (i_stat.ent_len > ELEN_W'(1)) ? ST_REPLAY : ST_END;
                    end else begin
                        o_cmd.op = OP_FIN;
                        n_end    = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_end       <= 1'b0;
            r_rep_idx   <= '0;
            r_rep_n     <= '0;
            r_then_byte <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_end       <= n_end;
            r_rep_idx   <= n_rep_idx;
            r_rep_n     <= n_rep_n;
            r_then_byte <= n_then_byte;
        end
    end

    assign o_s_tready = w_ready;

endmodule

@@ src/html_text_extractor_unit.sv @@
// Top level of the HTML text extractor: strips tags, skips script and style,
// decodes entities and collapses spaces. Depends on hte_pkg, hte_ctrl, hte_datapath.
//
//  Channel  | Direction | Signals                       | Contents
//  ---------+-----------+-------------------------------+------------------------------
//  s (in)   | slave     | tvalid tready tdata[7:0] tlast| tdata: in_byte;
//           |           |                               | tlast: end_of_input
//  m (out)  | master    | tvalid tready tdata[7:0] tuser| tdata: out_char;
//           |           | tlast                         | tuser: char_valid;
//           |           |                               | tlast: end_of_text
//
// A byte is taken whenever the controller is idle and the output register can take
// a result. A byte that breaks an entity match first gives one space; the controller
// then replays the buffered look-ahead bytes after the '&' one per cycle, while the
// output register can take them, through the shared text path, and then passes the
// breaking byte itself. After the final byte of a document, an entity still pending
// gets its space and the replay of its look-ahead bytes, then the held result goes.
// Reset is synchronous and active low; no memory needs clearing after it.
// A stalled output stops the controller; the next request is taken only when
// the output register is empty or its result leaves in the same cycle.
module html_text_extractor_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_char
    output logic       o_m_tuser,   // [0] char_valid
    output logic       o_m_tlast
);
    import hte_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller decides what the text path does each cycle.
    hte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds all parse state and the output register.
    hte_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

@@ src/hte_checker.sv @@
// Port-level checks for the HTML text extractor, bound to the top level.
// Depends on html_text_extractor_unit.
module hte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tuser,
    input logic       o_m_tlast
);

    // A stalled result keeps its contents.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
                                      $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // An empty result appears only as the end marker of a document.
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast)
        else $error("empty result without end of text");

    // An empty result carries a zero character.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 8'h00)
        else $error("empty result with nonzero character");

    // Carriage returns and tabs never reach the text output.
    a_no_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata != 8'h0D && o_m_tdata != 8'h09)
        else $error("control character in text output");

endmodule

bind html_text_extractor_unit hte_checker u_hte_checker (.*);

@@ tb/sv/tb_html_text_extractor_unit.sv @@
// Self-checking testbench for html_text_extractor_unit: streams HTML documents in and
// checks every text character, valid flag and end marker that comes out.
// Depends on hte_pkg and the html_text_extractor_unit RTL.
module tb_html_text_extractor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hte_pkg::*;

    // Limits of the behavior being predicted.
    localparam int TAG_MAX    = 15;  // tag characters that are kept
    localparam int ENT_MAX    = 5;   // entity look-ahead bytes, '&' included
    localparam int STEP_MAX   = 8;   // most text results one input byte can cause
    localparam int GAP_PCT    = 7;   // chance in a hundred of an idle cycle per side
    localparam int TARGET_BYTES = 320;
    localparam int DRAIN_CYCLES = 20;
    localparam int TAG_KINDS  = 20;

    // One input request: an HTML byte and the end-of-document flag.
    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_html_req;

    // One output request: text character, char_valid and end_of_text.
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
    } t_text_item;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic       s_tlast = 1'b0;    // end_of_input
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_char
    logic       m_tuser;           // [0] char_valid
    logic       m_tlast;           // end_of_text

    html_text_extractor_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Text predictor. It mirrors the extractor's state and works out the
    // characters each accepted byte releases.
    // ------------------------------------------------------------------
    bit         in_tag;
    bit         in_skip;       // inside script or style
    bit         ent_open;      // an '&' is waiting for the rest of its entity
    bit         last_blank;    // last character sent was a space or a newline
    logic [7:0] name_buf [TAG_MAX];
    int         name_len;
    logic [7:0] ent_buf [ENT_MAX];
    int         ent_fill;

    string      ent_names [4] = '{"&amp;", "&lt;", "&gt;", "&nbsp;"};
    logic [7:0] ent_chars [4] = '{CH_AMP, CH_LT, CH_GT, CH_SPACE};

    t_text_item expected_text[$];   // characters still owed by the block, oldest first
    t_text_item step_text[$];       // characters released by the byte being predicted

    task automatic clear_text_state();
        in_tag     = 1'b0;
        in_skip    = 1'b0;
        ent_open   = 1'b0;
        last_blank = 1'b0;
        name_len   = 0;
        ent_fill   = 0;
    endtask

    task automatic put_char(input logic [7:0] ch, input logic valid);
        if (step_text.size() < STEP_MAX)
            step_text.push_back('{ch: ch, valid: valid, last: 1'b0});
    endtask

    // Spaces are collapsed: one is sent only after a character that was
    // neither a space nor a newline. A newline also swallows the spaces after it.
    task automatic send_char(input logic [7:0] ch);
        if (ch == CH_SPACE) begin
            if (!last_blank)
                put_char(ch, 1'b1);
            last_blank = 1'b1;
        end else if (ch == CH_LF) begin
            put_char(ch, 1'b1);
            last_blank = 1'b1;
        end else begin
            put_char(ch, 1'b1);
            last_blank = 1'b0;
        end
    endtask

    function automatic bit name_starts(input string s);
        if (name_len < s.len())
            return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (name_buf[i] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic close_tag();
        in_tag = 1'b0;
        if (name_starts("script") || name_starts("style"))
            in_skip = 1'b1;
        if (name_starts("/script") || name_starts("/style"))
            in_skip = 1'b0;
        if (name_starts("br") || name_starts("/p") || name_starts("/div") ||
            name_starts("/h") || name_starts("p") || name_starts("li"))
            send_char(CH_LF);
    endtask

    // A byte with no entity match in progress.
    task automatic plain_char(input logic [7:0] b);
        bit is_digit;
        bit is_lower;
        bit is_upper;
        if (b == CH_LT) begin
            in_tag   = 1'b1;
            name_len = 0;
            return;
        end
        if (in_tag) begin
            if (b == CH_GT) begin
                close_tag();
            end else if (name_len < TAG_MAX) begin
                is_digit = (b >= "0" && b <= "9");
                is_lower = (b >= "a" && b <= "z");
                is_upper = (b >= "A" && b <= "Z");
                if (is_digit || is_lower || is_upper || b == CH_SLASH) begin
                    name_buf[name_len] = is_upper ? b + 8'h20 : b;
                    name_len++;
                end
            end
            return;
        end
        if (in_skip)
            return;
        if (b == CH_AMP) begin
            ent_open   = 1'b1;
            ent_buf[0] = b;
            ent_fill   = 1;
            return;
        end
        if (b == CH_CR)
            return;
        if (b == CH_LF || b == CH_TAB) begin
            send_char(CH_SPACE);
            return;
        end
        send_char(b);
    endtask

    // A broken entity gives one space; the look-ahead after '&' is then plain text.
    task automatic flush_entity();
        logic [7:0] saved [ENT_MAX];
        int         n;
        saved    = ent_buf;
        n        = ent_fill;
        ent_open = 1'b0;
        ent_fill = 0;
        send_char(CH_SPACE);
        for (int i = 1; i < n; i++)
            plain_char(saved[i]);
    endtask

    function automatic bit ent_head_matches(input int k, input int len);
        for (int i = 0; i < len; i++)
            if (ent_buf[i] != ent_names[k][i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic feed_char(input logic [7:0] b);
        int len;
        bit prefix;
        if (!ent_open) begin
            plain_char(b);
            return;
        end
        len    = ent_fill;
        prefix = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (ent_names[k].len() > len && ent_head_matches(k, len) &&
                ent_names[k][len] == b) begin
                if (ent_names[k].len() == len + 1) begin
                    ent_open = 1'b0;
                    ent_fill = 0;
                    send_char(ent_chars[k]);
                    return;
                end
                prefix = 1'b1;
            end
        end
        if (prefix && len < ENT_MAX) begin
            ent_buf[len] = b;
            ent_fill     = len + 1;
            return;
        end
        flush_entity();
        plain_char(b);
    endtask

    // Predicts the results of one accepted request and queues them.
    task automatic strip_html_byte(input logic [7:0] b, input logic eod);
        t_text_item tail;
        step_text.delete();
        feed_char(b);
        if (eod) begin
            if (ent_open)
                flush_entity();
            // A document that produced nothing still closes with one empty result.
            if (step_text.size() == 0)
                put_char(8'h00, 1'b0);
            tail      = step_text.pop_back();
            tail.last = 1'b1;
            step_text.push_back(tail);
            clear_text_state();
        end
        foreach (step_text[i])
            expected_text.push_back(step_text[i]);
    endtask

    // ------------------------------------------------------------------
    // Document generator. Documents are built from fragments of HTML and
    // turned into requests, with tlast on the final byte of each.
    // ------------------------------------------------------------------
    t_html_req  html_requests[$];
    logic [7:0] doc_bytes[$];

    string tag_names [TAG_KINDS] = '{
        "script", "style", "/script", "/style", "br", "/p", "/div", "/h", "/h3", "p",
        "li", "b", "span", "/li", "div", "scripted", "/styles", "a", "pre", "img"
    };
    string name_chars  = "abcdefghijklmnopqrstuvwxyz0123456789/ABCXYZ";
    logic [7:0] blanks [4] = '{CH_SPACE, CH_LF, CH_TAB, CH_CR};

    task automatic add_byte(input logic [7:0] b);
        doc_bytes.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // Letters come out in random case, since tag names are matched without case.
    task automatic add_mixed(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1))
                c = c ^ 8'h20;
            add_byte(c);
        end
    endtask

    task automatic add_tag();
        add_byte(CH_LT);
        add_mixed(tag_names[$urandom_range(0, TAG_KINDS - 1)]);
        case ($urandom_range(0, 4))
            0: begin
                // Long names run past the kept characters.
                repeat ($urandom_range(8, 16))
                    add_byte(name_chars[$urandom_range(0, name_chars.len() - 1)]);
            end
            1: add_text(" id=\"a1\"");
            2: add_byte(8'($urandom_range(0, 255)));
            default: ;
        endcase
        add_byte(CH_GT);
    endtask

    task automatic add_fragment();
        int         n;
        int         k;
        logic [7:0] c;
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    c = 8'($urandom_range(8'h21, 8'h7E));
                    if (c == CH_LT || c == CH_AMP)
                        c = "x";
                    add_byte(c);
                end
                if ($urandom_range(1))
                    add_byte(CH_SPACE);
            end
            3: begin
                repeat ($urandom_range(1, 4))
                    add_byte(blanks[$urandom_range(0, 3)]);
            end
            4, 5: add_tag();
            6: add_text(ent_names[$urandom_range(0, 3)]);
            7: begin
                // A partial entity followed by a byte that usually breaks it.
                k = $urandom_range(0, 3);
                n = $urandom_range(1, ent_names[k].len() - 1);
                for (int i = 0; i < n; i++)
                    add_byte(ent_names[k][i]);
                case ($urandom_range(0, 3))
                    0: add_byte(CH_LT);
                    1: add_byte(CH_AMP);
                    2: add_byte(blanks[$urandom_range(0, 3)]);
                    default: add_byte(8'($urandom_range(0, 255)));
                endcase
            end
            8: begin
                // Skipped block; tags inside it are still parsed.
                add_byte(CH_LT);
                add_mixed($urandom_range(1) ? "script" : "style");
                if ($urandom_range(1))
                    add_text(" type=x");
                add_byte(CH_GT);
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 3))
                        0: add_text("a<b && c");
                        1: add_tag();
                        2: add_text("&amp; x");
                        default: add_byte(8'($urandom_range(0, 255)));
                    endcase
                end
                if ($urandom_range(0, 3) != 0) begin
                    add_byte(CH_LT);
                    add_mixed($urandom_range(1) ? "/script" : "/style");
                    add_byte(CH_GT);
                end
            end
            9: add_byte(8'($urandom_range(0, 255)));
            10: begin
                // A stray '<' swallows the text up to the next '>'.
                add_byte(CH_LT);
                add_text("x y");
            end
            default: begin
                add_byte(CH_AMP);
                add_byte(CH_SPACE);
            end
        endcase
    endtask

    task automatic close_doc();
        foreach (doc_bytes[i])
            html_requests.push_back('{b: doc_bytes[i], last: (i == doc_bytes.size() - 1)});
        doc_bytes.delete();
    endtask

    // ------------------------------------------------------------------
    // Driver and monitor.
    // ------------------------------------------------------------------
    int  bytes_taken;
    int  docs_taken;
    int  results_checked;
    int  mismatches;
    bit  calm_stretch;
    t_html_req  next_req;
    t_text_item want;

    // A long run of requests goes by with neither side idling.
    assign calm_stretch = (bytes_taken >= 140 && bytes_taken < 240);

    // The driver predicts each request when the block takes it, then offers
    // the next one unless it decides to idle or has none left.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                strip_html_byte(s_tdata, s_tlast);
                bytes_taken++;
                if (s_tlast)
                    docs_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (html_requests.size() != 0 &&
                    (calm_stretch || $urandom_range(99) >= GAP_PCT)) begin
                    next_req = html_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.b;
                    s_tlast  <= next_req.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // The monitor checks every output request against the oldest prediction
    // and stalls the block now and then.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    $error("unexpected result: out_char %h char_valid %b end_of_text %b",
                           m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    want = expected_text.pop_front();
                    results_checked++;
                    if (m_tdata !== want.ch) begin
                        $error("out_char: expected %h, actual %h", want.ch, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.valid) begin
                        $error("char_valid: expected %b, actual %b", want.valid, m_tuser);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("end_of_text: expected %b, actual %b", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            m_tready <= calm_stretch || ($urandom_range(99) >= GAP_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        clear_text_state();

        // Nul and 0xFF bytes, CR dropped, LF and TAB collapsed into one space,
        // an upper-case break tag, two entities, and a broken entity at the end.
        add_byte(8'h00);
        add_text("A");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(CH_TAB);
        add_byte(8'hFF);
        add_text("<Br>&lt;&nbsp;&x");
        close_doc();
        // The document ends while an entity is still pending.
        add_text("&am");
        close_doc();
        // The document ends with no character at all.
        add_text("<i>");
        close_doc();

        while (html_requests.size() < TARGET_BYTES) begin
            repeat ($urandom_range(1, 10))
                add_fragment();
            close_doc();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (html_requests.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d HTML bytes in %0d documents, with stalls on both sides.",
                 bytes_taken, docs_taken);
        $display("Checked %0d text results field by field.", results_checked);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: the whole run needs well under a tenth of this.
    initial begin
        #1_000_000;
        $display("Timeout with %0d results still expected.", expected_text.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
src/hte_pkg.sv
src/hte_datapath.sv
src/hte_ctrl.sv
src/html_text_extractor_unit.sv
src/hte_checker.sv
tb/sv/tb_html_text_extractor_unit.sv
